// File: hdl/rc_channel_scaler_deadzone_top_assert.svh
// Assertion macros shared by the RTL of the channel scaler.
`ifndef RC_CHANNEL_SCALER_DEADZONE_TOP_ASSERT_SVH
`define RC_CHANNEL_SCALER_DEADZONE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rcsd_pkg.sv
package rcsd_pkg;

	typedef struct packed {
		logic [15:0] width_ch1;
		logic [15:0] width_ch2;
		logic [15:0] width_ch3;
		logic [15:0] width_ch4;
		logic [15:0] width_ch5;
		logic [15:0] width_ch6;
	} rcsd_in_t;

	typedef struct packed {
		logic        radio_on;
		logic [16:0] throttle_out;
		logic [16:0] stick_b_out;
		logic [16:0] stick_c_out;
		logic [16:0] stick_d_out;
		logic        switch_a;
		logic        switch_b;
	} rcsd_out_t;

	localparam int CfgIdxW = 4;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CfgOffCenter    = 4'd0;
	localparam logic [CfgIdxW-1:0] CfgOffTolerance = 4'd1;
	localparam logic [CfgIdxW-1:0] CfgSwitchAThr   = 4'd2;
	localparam logic [CfgIdxW-1:0] CfgSwitchBThr   = 4'd3;
	localparam logic [CfgIdxW-1:0] CfgDeadzoneOn   = 4'd4;
	localparam logic [CfgIdxW-1:0] CfgDeadzoneW    = 4'd5;
	localparam logic [CfgIdxW-1:0] CfgMappedMid    = 4'd6;
	localparam logic [CfgIdxW-1:0] CfgMappedLow    = 4'd7;

	// Gain magnitudes in unsigned Q1.15.
	localparam logic [15:0] Ch1Gain = 16'd33325;
	localparam logic [15:0] Ch2Gain = 16'd31736;
	localparam logic [15:0] Ch3Gain = 16'd30589;
	localparam logic [15:0] Ch4Gain = 16'd30310;

	// Offsets already scaled by 2^15.
	localparam logic [26:0] Ch1Base = 27'(2035 * 32768);
	localparam logic [26:0] Ch2Base = 27'(922 * 32768);
	localparam logic [26:0] Ch3Base = 27'(811 * 32768);
	localparam logic [26:0] Ch4Base = 27'(1814 * 32768);

	// Largest throttle and fourth-stick values the maps can produce.
	localparam logic [16:0] Ch1Max = 17'd2035;
	localparam logic [16:0] Ch4Max = 17'd1814;

	localparam int NumSticks = 3;

endpackage

// File: hdl/rc_channel_scaler_deadzone_top.sv
// Maps six RC pulse widths to throttle, three stick values and two switch bits.
// One transaction is taken per clock and busy never rises; the result appears
// on result with done high after the register stages below, and the receiver
// cannot hold it off. The four register stages are: constant-gain multiply with
// the radio-presence and switch compares, offset add with truncation and clamp
// at zero, deadzone distance compares, and the final deadzone select. Write
// configuration only while no transaction is in flight; cfg_ready is always high
// and writes to an unknown index are dropped.
`include "rc_channel_scaler_deadzone_top_assert.svh"

module rc_channel_scaler_deadzone_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rcsd_pkg::rcsd_in_t            channels,
	output logic                          done,
	output rcsd_pkg::rcsd_out_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcsd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rcsd_pkg::CfgDataW-1:0] cfg_data
);
	import rcsd_pkg::*;

	logic [15:0] off_center_q;
	logic [15:0] off_tolerance_q;
	logic [15:0] switch_a_thr_q;
	logic [15:0] switch_b_thr_q;
	logic        deadzone_on_q;
	logic [9:0]  deadzone_w_q;
	logic [15:0] mapped_mid_q;
	logic [15:0] mapped_low_q;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic        off_s1, off_s2, off_s3;
	logic        swa_s1, swa_s2, swa_s3;
	logic        swb_s1, swb_s2, swb_s3;
	logic [31:0] prod1_s1, prod2_s1, prod3_s1, prod4_s1;
	logic [16:0] thr_s2, thr_s3;
	logic [16:0] stick_s2 [NumSticks];
	logic [16:0] stick_s3 [NumSticks];
	logic        thr_low_s3;
	logic        in_zone_s3 [NumSticks];
	logic        above_s3 [NumSticks];
	logic        below_s3 [NumSticks];
	rcsd_out_t   result_s4;

	logic        accept;
	logic        radio_off;
	logic [16:0] ch5_diff;
	logic [16:0] ch5_dist;
	logic [16:0] thr_map;
	logic [16:0] stick_map [NumSticks];
	logic [17:0] mid_diff [NumSticks];
	logic [16:0] mid_dist [NumSticks];
	logic [16:0] thr_shaped;
	logic [16:0] stick_shaped [NumSticks];
	logic [16:0] dz_ext;
	logic [16:0] mid_ext;

	// Truncated map: negative or zero numerators clamp to zero, positive ones
	// drop the fractional bits, which is truncation toward zero.
	function automatic logic [16:0] lin_scale(input logic [31:0] prod,
		input logic [26:0] base, input logic negate);
		logic signed [33:0] p;
		logic signed [33:0] b;
		logic signed [33:0] n;
		p = signed'({2'b00, prod});
		b = signed'({7'b0, base});
		n = negate ? (b - p) : (p - b);
		return (n <= 34'sd0) ? 17'd0 : n[31:15];
	endfunction

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;
	assign dz_ext = {7'b0, deadzone_w_q};
	assign mid_ext = {1'b0, mapped_mid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_center_q <= 16'd1000;
			off_tolerance_q <= 16'd50;
			switch_a_thr_q <= 16'd1500;
			switch_b_thr_q <= 16'd1500;
			deadzone_on_q <= 1'b1;
			deadzone_w_q <= 10'd20;
			mapped_mid_q <= 16'd500;
			mapped_low_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgOffCenter:    off_center_q <= cfg_data;
				CfgOffTolerance: off_tolerance_q <= cfg_data;
				CfgSwitchAThr:   switch_a_thr_q <= cfg_data;
				CfgSwitchBThr:   switch_b_thr_q <= cfg_data;
				CfgDeadzoneOn:   deadzone_on_q <= cfg_data[0];
				CfgDeadzoneW:    deadzone_w_q <= cfg_data[9:0];
				CfgMappedMid:    mapped_mid_q <= cfg_data;
				CfgMappedLow:    mapped_low_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage 1: products and the channel-five / channel-six compares.
	always_comb begin
		ch5_diff = {1'b0, channels.width_ch5} - {1'b0, off_center_q};
		ch5_dist = ch5_diff[16] ? (17'd0 - ch5_diff) : ch5_diff;
		radio_off = (channels.width_ch5 == 16'd0) || (ch5_dist < {1'b0, off_tolerance_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod1_s1 <= {16'b0, channels.width_ch1} * {16'b0, Ch1Gain};
		prod2_s1 <= {16'b0, channels.width_ch2} * {16'b0, Ch2Gain};
		prod3_s1 <= {16'b0, channels.width_ch3} * {16'b0, Ch3Gain};
		prod4_s1 <= {16'b0, channels.width_ch4} * {16'b0, Ch4Gain};
		off_s1 <= radio_off;
		swa_s1 <= channels.width_ch5 >= switch_a_thr_q;
		swb_s1 <= channels.width_ch6 >= switch_b_thr_q;
	end

	// Stage 2: offsets and truncation.
	always_comb begin
		thr_map = lin_scale(prod1_s1, Ch1Base, 1'b1);
		stick_map[0] = lin_scale(prod2_s1, Ch2Base, 1'b0);
		stick_map[1] = lin_scale(prod3_s1, Ch3Base, 1'b0);
		stick_map[2] = lin_scale(prod4_s1, Ch4Base, 1'b1);
	end

	always_ff @(posedge clk) begin
		thr_s2 <= thr_map;
		for (int i = 0; i < NumSticks; i++) begin
			stick_s2[i] <= stick_map[i];
		end
		off_s2 <= off_s1;
		swa_s2 <= swa_s1;
		swb_s2 <= swb_s1;
	end

	// Stage 3: stick distances from the center and the throttle vs the deadzone.
	always_comb begin
		for (int i = 0; i < NumSticks; i++) begin
			mid_diff[i] = {1'b0, stick_s2[i]} - {1'b0, mid_ext};
			mid_dist[i] = mid_diff[i][17] ? 17'(18'd0 - mid_diff[i]) : mid_diff[i][16:0];
		end
	end

	always_ff @(posedge clk) begin
		thr_s3 <= thr_s2;
		thr_low_s3 <= thr_s2 < dz_ext;
		for (int i = 0; i < NumSticks; i++) begin
			stick_s3[i] <= stick_s2[i];
			in_zone_s3[i] <= mid_dist[i] < dz_ext;
			above_s3[i] <= !mid_diff[i][17] && (mid_diff[i] != 18'd0);
			below_s3[i] <= mid_diff[i][17];
		end
		off_s3 <= off_s2;
		swa_s3 <= swa_s2;
		swb_s3 <= swb_s2;
	end

	// Stage 4: deadzone select and the clear while the radio is off. Sums cannot
	// leave 17 bits since the maps stay below 2^16 and the deadzone below 2^10.
	always_comb begin
		if (!deadzone_on_q) begin
			thr_shaped = thr_s3;
		end else if (thr_low_s3) begin
			thr_shaped = {1'b0, mapped_low_q};
		end else begin
			thr_shaped = thr_s3 - dz_ext;
		end
		for (int i = 0; i < NumSticks; i++) begin
			if (!deadzone_on_q) begin
				stick_shaped[i] = stick_s3[i];
			end else if (in_zone_s3[i]) begin
				stick_shaped[i] = mid_ext;
			end else if (above_s3[i]) begin
				stick_shaped[i] = stick_s3[i] - dz_ext;
			end else if (below_s3[i]) begin
				stick_shaped[i] = stick_s3[i] + dz_ext;
			end else begin
				stick_shaped[i] = stick_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (off_s3) begin
			result_s4 <= '0;
		end else begin
			result_s4.radio_on <= 1'b1;
			result_s4.throttle_out <= thr_shaped;
			result_s4.stick_b_out <= stick_shaped[0];
			result_s4.stick_c_out <= stick_shaped[1];
			result_s4.stick_d_out <= stick_shaped[2];
			result_s4.switch_a <= swa_s3;
			result_s4.switch_b <= swb_s3;
		end
	end

	assign done = vld_s4;
	assign result = result_s4;

	`RCSD_ASSERT_IMPL(a_off_all_zero, clk, arst_n,
		done && !result.radio_on,
		result.throttle_out == 17'd0 && result.stick_b_out == 17'd0 &&
		result.stick_c_out == 17'd0 && result.stick_d_out == 17'd0 &&
		!result.switch_a && !result.switch_b,
		"radio off but result fields not cleared")
	`RCSD_ASSERT_IMPL(a_thr_bound, clk, arst_n,
		done && result.radio_on && !deadzone_on_q,
		result.throttle_out <= Ch1Max,
		"throttle beyond its map range")
	`RCSD_ASSERT_IMPL(a_stick_d_bound, clk, arst_n,
		done && result.radio_on && !deadzone_on_q,
		result.stick_d_out <= Ch4Max,
		"fourth stick beyond its map range")
	`RCSD_ASSERT_NEXT(a_stage3_delivers, clk, arst_n,
		vld_s3, done,
		"transaction in the last compare stage did not produce a result")
endmodule
